>>> rtl/dwips_pkg.sv
// Shared types and constants for the dual-wheel incremental PI speed controller.
package dwips_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_KP_LEFT     = 3'd0;
	localparam logic [2:0] REG_KI_LEFT     = 3'd1;
	localparam logic [2:0] REG_KP_RIGHT    = 3'd2;
	localparam logic [2:0] REG_KI_RIGHT    = 3'd3;
	localparam logic [2:0] REG_STEP_LIMIT  = 3'd4;
	localparam logic [2:0] REG_DRIVE_LIMIT = 3'd5;

	// Register values after reset.
	localparam logic [15:0] KP_RESET          = 16'd768;
	localparam logic [15:0] KI_RESET          = 16'd2304;
	localparam logic [14:0] STEP_LIMIT_RESET  = 15'd1000;
	localparam logic [14:0] DRIVE_LIMIT_RESET = 15'd8000;

	// Pipeline depth from the input register to the result register.
	localparam int NSTAGES = 6;

	// Load strobes for the wheel datapath, one per pipeline stage.
	typedef struct packed {
		logic ld_in;
		logic ld_err;
		logic ld_mul;
		logic ld_inc;
		logic ld_acc;
		logic ld_out;
	} pipe_ctl_t;

endpackage

>>> rtl/dwips_wheel.sv
// Datapath of one wheel: error, PI increment, step clamp, accumulator and drive.
module dwips_wheel #(
	parameter int FRAC_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dwips_pkg::pipe_ctl_t ctl,
	input  logic [15:0]         kp,
	input  logic [15:0]         ki,
	input  logic [14:0]         step_limit,
	input  logic [14:0]         drive_limit,
	input  logic signed [15:0]  target,
	input  logic signed [15:0]  measured,
	output logic signed [15:0]  drive
);

	localparam int AW = 16 + FRAC_BITS;
	localparam int SW = 35;

	logic signed [15:0]   target_s1, measured_s1;
	logic signed [15:0]   err_s2;
	logic signed [16:0]   diff_s2;
	logic signed [15:0]   prev_err_q;
	logic signed [33:0]   prod_p_s3;
	logic signed [32:0]   prod_i_s3;
	logic signed [AW-1:0] inc_s4;
	logic signed [AW-1:0] accum_q;
	logic signed [15:0]   drive_s6;

	logic signed [16:0]   e_wide;
	logic signed [15:0]   err_sat;
	logic signed [16:0]   diff_d;
	logic signed [16:0]   kp_x, ki_x;
	logic signed [33:0]   prod_p_d;
	logic signed [32:0]   prod_i_d;
	logic signed [SW-1:0] sum, slim, nslim;
	logic signed [AW-1:0] inc_d;
	logic signed [AW:0]   acc_sum, dlim, ndlim;
	logic signed [AW-1:0] accum_d;
	logic                 neg;
	logic signed [AW-1:0] mag;
	logic signed [15:0]   whole;
	logic signed [15:0]   drive_d;

	always_comb begin
		// Error in 17 bits, then saturated back to 16.
		e_wide = {target_s1[15], target_s1} - {measured_s1[15], measured_s1};
		if (e_wide[16] != e_wide[15]) begin
			err_sat = e_wide[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			err_sat = e_wide[15:0];
		end
		diff_d = {err_sat[15], err_sat} - {prev_err_q[15], prev_err_q};

		kp_x     = {1'b0, kp};
		ki_x     = {1'b0, ki};
		prod_p_d = kp_x * diff_s2;
		prod_i_d = ki_x * err_s2;

		sum   = SW'(prod_p_s3) + SW'(prod_i_s3);
		slim  = {{(SW - 15 - FRAC_BITS){1'b0}}, step_limit, {FRAC_BITS{1'b0}}};
		nslim = -slim;
		if (sum > slim) begin
			inc_d = slim[AW-1:0];
		end else if (sum < nslim) begin
			inc_d = nslim[AW-1:0];
		end else begin
			inc_d = sum[AW-1:0];
		end

		acc_sum = (AW+1)'(accum_q) + (AW+1)'(inc_s4);
		dlim    = {2'b00, drive_limit, {FRAC_BITS{1'b0}}};
		ndlim   = -dlim;
		if (acc_sum > dlim) begin
			accum_d = dlim[AW-1:0];
		end else if (acc_sum < ndlim) begin
			accum_d = ndlim[AW-1:0];
		end else begin
			accum_d = acc_sum[AW-1:0];
		end

		// Truncate toward zero: shift the magnitude, then restore the sign.
		neg     = accum_q[AW-1];
		mag     = neg ? -accum_q : accum_q;
		whole   = mag[AW-1:FRAC_BITS];
		drive_d = neg ? -whole : whole;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			accum_q    <= '0;
		end else begin
			if (ctl.ld_err) begin
				prev_err_q <= err_sat;
			end
			if (ctl.ld_acc) begin
				accum_q <= accum_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_in) begin
			target_s1   <= target;
			measured_s1 <= measured;
		end
		if (ctl.ld_err) begin
			err_s2  <= err_sat;
			diff_s2 <= diff_d;
		end
		if (ctl.ld_mul) begin
			prod_p_s3 <= prod_p_d;
			prod_i_s3 <= prod_i_d;
		end
		if (ctl.ld_inc) begin
			inc_s4 <= inc_d;
		end
		if (ctl.ld_out) begin
			drive_s6 <= drive_d;
		end
	end

	assign drive = drive_s6;

endmodule

>>> rtl/dual_wheel_incremental_pi_speed.sv
// Stages in order: input, error, product, increment, accumulator, result.
// Throughput: one beat per cycle unless a result stalls; the accumulator
// add/clamp closes its loop in one stage; back-to-back ticks need no wait.
// Stages with nothing to pass on take new beats while a result is stalled.
// Reset loads default gains and limits and zeroes errors and accumulators.
module dual_wheel_incremental_pi_speed #(
	parameter int FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] target_left,
	input  logic signed [15:0] target_right,
	input  logic signed [15:0] measured_left,
	input  logic signed [15:0] measured_right,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] drive_left,
	output logic signed [15:0] drive_right
);

	localparam int N = dwips_pkg::NSTAGES;

	logic [15:0] kp_left_q, ki_left_q, kp_right_q, ki_right_q;
	logic [14:0] step_limit_q, drive_limit_q;

	logic [N-1:0] v_q;
	logic [N-1:0] rdy;
	logic [N-1:0] ld;
	dwips_pkg::pipe_ctl_t ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_left_q     <= dwips_pkg::KP_RESET;
			ki_left_q     <= dwips_pkg::KI_RESET;
			kp_right_q    <= dwips_pkg::KP_RESET;
			ki_right_q    <= dwips_pkg::KI_RESET;
			step_limit_q  <= dwips_pkg::STEP_LIMIT_RESET;
			drive_limit_q <= dwips_pkg::DRIVE_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dwips_pkg::REG_KP_LEFT:     kp_left_q     <= cfg_data;
				dwips_pkg::REG_KI_LEFT:     ki_left_q     <= cfg_data;
				dwips_pkg::REG_KP_RIGHT:    kp_right_q    <= cfg_data;
				dwips_pkg::REG_KI_RIGHT:    ki_right_q    <= cfg_data;
				dwips_pkg::REG_STEP_LIMIT:  step_limit_q  <= cfg_data[14:0];
				dwips_pkg::REG_DRIVE_LIMIT: drive_limit_q <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	// A stage can load when it is empty or its occupant moves on this cycle.
	always_comb begin
		rdy[N-1] = !v_q[N-1] || !out_stall;
		for (int k = N - 2; k >= 0; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
		ld[0] = in_valid && rdy[0];
		for (int k = 1; k < N; k++) begin
			ld[k] = v_q[k-1] && rdy[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < N; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign ctl.ld_in  = ld[0];
	assign ctl.ld_err = ld[1];
	assign ctl.ld_mul = ld[2];
	assign ctl.ld_inc = ld[3];
	assign ctl.ld_acc = ld[4];
	assign ctl.ld_out = ld[5];

	assign in_stall  = !rdy[0];
	assign out_valid = v_q[N-1];

	dwips_wheel #(.FRAC_BITS(FRAC_BITS)) u_left (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.kp          (kp_left_q),
		.ki          (ki_left_q),
		.step_limit  (step_limit_q),
		.drive_limit (drive_limit_q),
		.target      (target_left),
		.measured    (measured_left),
		.drive       (drive_left)
	);

	dwips_wheel #(.FRAC_BITS(FRAC_BITS)) u_right (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.kp          (kp_right_q),
		.ki          (ki_right_q),
		.step_limit  (step_limit_q),
		.drive_limit (drive_limit_q),
		.target      (target_right),
		.measured    (measured_right),
		.drive       (drive_right)
	);

endmodule

>>> bench/tb_dual_wheel_incremental_pi_speed.sv
// Testbench for the dual-wheel PI speed block: a directed table, then random ticks checked by a model.
`timescale 1ns / 1ps

module tb_dual_wheel_incremental_pi_speed;

	localparam int FRAC = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 8;
	localparam int TICKS_PER_PHASE = 75;
	localparam int SETTLE_CYCLES = 10;

	// Indexes past the last register; writes to them must be ignored.
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [2:0]        idx;
		logic [15:0]       data;
		logic signed [15:0] tl, tr, ml, mr;
		bit                typed;
		logic signed [15:0] el, er;
	} plan_row_t;

	typedef struct packed {
		logic signed [15:0] l;
		logic signed [15:0] r;
	} drive_pair_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] target_left, target_right, measured_left, measured_right;
	logic out_valid;
	logic out_stall;
	logic signed [15:0] drive_left, drive_right;

	// Expected drives typed into the directed table ride along with their beat.
	bit beat_typed;
	logic signed [15:0] typed_l, typed_r;

	// Mirror of the block's registers and wheel state.
	longint gain_p[2], gain_i[2];
	longint step_lim, drive_lim;
	longint prev_err[2], acc[2];

	drive_pair_t pending_drives[$];
	plan_row_t plan[$];
	int mismatches;
	bit calm;
	int want_hold;
	int hold_left;
	int stall_burst;
	int setpt_l, setpt_r;

	dual_wheel_incremental_pi_speed #(.FRAC_BITS(FRAC)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.target_left(target_left),
		.target_right(target_right),
		.measured_left(measured_left),
		.measured_right(measured_right),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive_left(drive_left),
		.drive_right(drive_right)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	function automatic longint clamp_mag(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// One control tick for one wheel; updates the mirrored state.
	function automatic logic signed [15:0] advance_wheel(int w, logic signed [15:0] tgt,
			logic signed [15:0] meas);
		longint err;
		longint inc;
		longint drv;
		err = longint'(tgt) - longint'(meas);
		if (err > 32767)
			err = 32767;
		if (err < -32768)
			err = -32768;
		inc = gain_p[w] * (err - prev_err[w]) + gain_i[w] * err;
		prev_err[w] = err;
		inc = clamp_mag(inc, step_lim <<< FRAC);
		acc[w] = clamp_mag(acc[w] + inc, drive_lim <<< FRAC);
		// Truncate toward zero, so a small negative drive reads as zero.
		if (acc[w] < 0)
			drv = -((-acc[w]) >>> FRAC);
		else
			drv = acc[w] >>> FRAC;
		return 16'(drv);
	endfunction

	function automatic void apply_write(logic [2:0] idx, logic [15:0] data);
		case (idx)
			dwips_pkg::REG_KP_LEFT: gain_p[0] = longint'(data);
			dwips_pkg::REG_KI_LEFT: gain_i[0] = longint'(data);
			dwips_pkg::REG_KP_RIGHT: gain_p[1] = longint'(data);
			dwips_pkg::REG_KI_RIGHT: gain_i[1] = longint'(data);
			dwips_pkg::REG_STEP_LIMIT: step_lim = longint'(data[14:0]);
			dwips_pkg::REG_DRIVE_LIMIT: drive_lim = longint'(data[14:0]);
			default: ;
		endcase
	endfunction

	task automatic report(input string what, input logic signed [15:0] exp_v,
			input logic signed [15:0] got_v);
		$display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
		mismatches++;
	endtask

	// Track register writes, accepted input beats and accepted result beats.
	always @(posedge clk) begin
		drive_pair_t want;
		if (arst_n) begin
			if (cfg_we)
				apply_write(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				want.l = advance_wheel(0, target_left, measured_left);
				want.r = advance_wheel(1, target_right, measured_right);
				if (beat_typed) begin
					want.l = typed_l;
					want.r = typed_r;
				end
				pending_drives.push_back(want);
			end
			if (out_valid && !out_stall) begin
				if (pending_drives.size() == 0) begin
					report("result beat with nothing pending, drive_left", 0, drive_left);
				end else begin
					want = pending_drives.pop_front();
					if (drive_left !== want.l)
						report("drive_left", want.l, drive_left);
					if (drive_right !== want.r)
						report("drive_right", want.r, drive_right);
				end
			end
		end
	end

	// Receiver: short random stall bursts, a long hold on request, none when calm.
	always @(negedge clk) begin
		if (want_hold > 0) begin
			hold_left = want_hold;
			want_hold = 0;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else if (calm) begin
			out_stall = 1'b0;
		end else if (stall_burst > 0) begin
			out_stall = 1'b1;
			stall_burst--;
		end else if ($urandom_range(0, 4) == 0) begin
			out_stall = 1'b1;
			stall_burst = $urandom_range(0, 2);
		end else begin
			out_stall = 1'b0;
		end
	end

	task automatic add_tick(logic signed [15:0] tl, tr, ml, mr, bit typed = 0,
			logic signed [15:0] el = 0, logic signed [15:0] er = 0);
		plan_row_t row;
		row.kind = ROW_TICK;
		row.idx = '0;
		row.data = '0;
		row.tl = tl;
		row.tr = tr;
		row.ml = ml;
		row.mr = mr;
		row.typed = typed;
		row.el = el;
		row.er = er;
		plan.push_back(row);
	endtask

	task automatic add_write(logic [2:0] idx, logic [15:0] data);
		plan_row_t row;
		row = '{default: '0, kind: ROW_WRITE};
		row.idx = idx;
		row.data = data;
		plan.push_back(row);
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_tick(logic signed [15:0] tl, tr, ml, mr, bit typed,
			logic signed [15:0] el, er);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		target_left = tl;
		target_right = tr;
		measured_left = ml;
		measured_right = mr;
		beat_typed = typed;
		typed_l = el;
		typed_r = er;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Stop offering beats and wait until every pending result has come out.
	task automatic settle();
		in_valid = 1'b0;
		beat_typed = 1'b0;
		while (pending_drives.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 2048));
		endcase
	endfunction

	function automatic logic [15:0] pick_limit();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd32767;
			2: return 16'($urandom_range(0, 32767));
			default: return 16'($urandom_range(1, 3000));
		endcase
	endfunction

	function automatic logic signed [15:0] edge_speed();
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sd0;
			3: return -16'sd1;
			default: return 16'sd1;
		endcase
	endfunction

	function automatic logic signed [15:0] near_setpoint(int sp);
		return 16'(sp + int'($urandom_range(0, 600)) - 300);
	endfunction

	task automatic random_tick();
		case ($urandom_range(0, 9))
			0: send_tick(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 0, 0, 0);
			1: send_tick(edge_speed(), edge_speed(), edge_speed(), edge_speed(), 0, 0, 0);
			default: begin
				// Mostly a wheel tracking a setpoint that moves now and then.
				if ($urandom_range(0, 15) == 0)
					setpt_l = int'($urandom_range(0, 40000)) - 20000;
				if ($urandom_range(0, 15) == 0)
					setpt_r = int'($urandom_range(0, 40000)) - 20000;
				send_tick(16'(setpt_l), 16'(setpt_r), near_setpoint(setpt_l),
					near_setpoint(setpt_r), 0, 0, 0);
			end
		endcase
	endtask

	initial begin
		plan_row_t row;
		logic [15:0] val;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		target_left = '0;
		target_right = '0;
		measured_left = '0;
		measured_right = '0;
		beat_typed = 1'b0;
		typed_l = '0;
		typed_r = '0;
		out_stall = 1'b0;
		mismatches = 0;
		calm = 1'b0;
		want_hold = 0;
		hold_left = 0;
		stall_burst = 0;
		setpt_l = 0;
		setpt_r = 0;
		gain_p[0] = longint'(dwips_pkg::KP_RESET);
		gain_p[1] = longint'(dwips_pkg::KP_RESET);
		gain_i[0] = longint'(dwips_pkg::KI_RESET);
		gain_i[1] = longint'(dwips_pkg::KI_RESET);
		step_lim = longint'(dwips_pkg::STEP_LIMIT_RESET);
		drive_lim = longint'(dwips_pkg::DRIVE_LIMIT_RESET);
		prev_err = '{0, 0};
		acc = '{0, 0};

		// Directed table, starting from the reset gains and limits.
		add_tick(0, 0, 0, 0, 1, 0, 0);
		// Opposite extremes saturate the error; each increment hits the step limit
		// until the drive reaches its limit.
		for (int k = 1; k <= 9; k++)
			add_tick(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 1,
				16'(k < 8 ? 1000 * k : 8000), 16'(k < 8 ? -1000 * k : -8000));
		add_tick(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
		add_tick(100, -100, 90, -95);
		add_tick(-1, 1, 0, 0);
		// A zero drive limit pins both drives at zero.
		add_write(dwips_pkg::REG_DRIVE_LIMIT, 16'd0);
		add_tick(123, -456, 0, 0, 1, 0, 0);
		// A zero step limit keeps the cleared drive from moving.
		add_write(dwips_pkg::REG_DRIVE_LIMIT, 16'd8000);
		add_write(dwips_pkg::REG_STEP_LIMIT, 16'd0);
		add_tick(5000, -5000, 0, 0, 1, 0, 0);
		// Half-count increments show truncation toward zero on both signs.
		add_write(dwips_pkg::REG_STEP_LIMIT, 16'd1000);
		add_write(dwips_pkg::REG_KP_LEFT, 16'd0);
		add_write(dwips_pkg::REG_KI_LEFT, 16'd128);
		add_write(dwips_pkg::REG_KP_RIGHT, 16'd0);
		add_write(dwips_pkg::REG_KI_RIGHT, 16'd128);
		add_tick(-1, 1, 0, 0, 1, 0, 0);
		add_tick(-1, 1, 0, 0, 1, -1, 1);
		add_write(REG_SPARE_6, 16'hFFFF);
		add_write(REG_SPARE_7, 16'h0000);
		add_tick(-300, 700, 200, -100);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_reg(row.idx, row.data);
			end else begin
				send_tick(row.tl, row.tr, row.ml, row.mr, row.typed, row.el, row.er);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			calm = (p == PHASES - 1) || (p == 4);
			for (int r = 0; r < 6; r++) begin
				if (p == 0)
					val = (r < 4) ? 16'hFFFF : 16'd32767;
				else if (p == 1)
					val = (r < 4) ? 16'd0 : 16'd32767;
				else
					val = (r < 4) ? pick_gain() : pick_limit();
				write_reg(3'(r), val);
			end
			setpt_l = int'($urandom_range(0, 40000)) - 20000;
			setpt_r = int'($urandom_range(0, 40000)) - 20000;
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				// Hold the result side long enough for the pipeline to back up.
				if (p == 2 && n == 20)
					want_hold = 40;
				// Let the block drain completely in the middle of a phase.
				if (p == 3 && n == 30)
					settle();
				random_tick();
			end
		end
		settle();

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
rtl/dwips_pkg.sv
rtl/dwips_wheel.sv
rtl/dual_wheel_incremental_pi_speed.sv
bench/tb_dual_wheel_incremental_pi_speed.sv
